### hw/rtl/motor_feedback_unwrap_unit_macros.svh
// Assertion macros used by the port-level checker of the feedback unwrap unit.
`ifndef MOTOR_FEEDBACK_UNWRAP_UNIT_MACROS_SVH
`define MOTOR_FEEDBACK_UNWRAP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MFU_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MFU_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mfu_pkg.sv
// Shared types and constants of the motor feedback unwrap unit.
`timescale 1ns / 1ps
package mfu_pkg;

    localparam int NUM_BUSES_DEF      = 3;
    localparam int MOTORS_PER_BUS_DEF = 8;
    localparam int MASK_W             = 24;

    localparam logic [10:0] ID_FIRST = 11'h201;
    localparam logic [10:0] ID_LAST  = 11'h208;
    localparam logic [10:0] ID_BASE  = 11'h200;

    localparam logic signed [15:0] HALF_TURN = 16'sd4096;
    localparam logic signed [17:0] FULL_TURN = 18'sd8192;

    // Decoded feedback word
    typedef struct packed {
        logic               hit;
        logic [1:0]         bus;
        logic [3:0]         slot;
        logic [15:0]        angle;
        logic signed [15:0] speed;
        logic signed [15:0] torque;
        logic [7:0]         temp;
    } mfu_frame_t;

    // Per-motor stored state
    typedef struct packed {
        logic [15:0]        prev;
        logic signed [31:0] total;
    } mfu_entry_t;

endpackage

### hw/rtl/mfu_decode.sv
// Frame filter and field decode: identifier window, bus/slot range and registration check.
`timescale 1ns / 1ps
module mfu_decode #(
    parameter int NUM_BUSES      = mfu_pkg::NUM_BUSES_DEF,
    parameter int MOTORS_PER_BUS = mfu_pkg::MOTORS_PER_BUS_DEF,
    parameter int IDX_W          = 5
) (
    input  logic [1:0]                  bus_index,
    input  logic [10:0]                 frame_id,
    input  logic [31:0]                 payload_high,
    input  logic [31:0]                 payload_low,
    input  logic [mfu_pkg::MASK_W-1:0]  registered_mask,
    output mfu_pkg::mfu_frame_t         frame,
    output logic [IDX_W-1:0]            idx
);
    import mfu_pkg::*;

    localparam int NUM_MOTORS = NUM_BUSES * MOTORS_PER_BUS;

    logic [10:0] slot_full;
    logic [3:0]  slot;
    logic        id_ok;
    logic        bus_ok;
    logic        slot_ok;
    logic        in_mask;
    logic [5:0]  flat;

    assign slot_full = frame_id - ID_BASE;
    assign slot      = slot_full[3:0];
    assign id_ok     = (frame_id >= ID_FIRST) && (frame_id <= ID_LAST);
    assign bus_ok    = 32'(bus_index) < NUM_BUSES;
    assign slot_ok   = 32'(slot) <= MOTORS_PER_BUS;
    assign flat      = 6'(bus_index) * 6'(MOTORS_PER_BUS) + 6'(slot) - 6'd1;
    assign in_mask   = (32'(flat) < MASK_W) && (32'(flat) < NUM_MOTORS);

    always_comb
    begin
        frame.hit    = id_ok && bus_ok && slot_ok && in_mask && registered_mask[flat[4:0]];
        frame.bus    = bus_index;
        frame.slot   = slot;
        frame.angle  = payload_high[31:16];
        frame.speed  = payload_high[15:0];
        frame.torque = payload_low[31:16];
        frame.temp   = payload_low[15:8];
    end

    assign idx = flat[IDX_W-1:0];

endmodule

### hw/rtl/mfu_unwrap.sv
// Turn-corrected angle difference and saturating accumulate for one motor.
`timescale 1ns / 1ps
module mfu_unwrap (
    input  logic [15:0]          angle,
    input  logic                 seeded,
    input  mfu_pkg::mfu_entry_t  cur,
    output mfu_pkg::mfu_entry_t  upd
);
    import mfu_pkg::*;

    localparam logic signed [33:0] SAT_HI = 34'sd2147483647;
    localparam logic signed [33:0] SAT_LO = -34'sd2147483648;

    logic [15:0]        prev_eff;
    logic signed [17:0] diff;
    logic signed [15:0] d16;
    logic signed [17:0] adj;
    logic signed [33:0] sum;

    // First frame seeds with its own angle, so the step is zero
    assign prev_eff = seeded ? cur.prev : angle;
    assign diff     = $signed({2'b00, angle}) - $signed({2'b00, prev_eff});
    assign d16      = diff[15:0];

    always_comb
    begin
        priority if (d16 >= HALF_TURN)
            adj = diff - FULL_TURN;
        else if (d16 <= -HALF_TURN)
            adj = diff + FULL_TURN;
        else
            adj = diff;
    end

    assign sum = {{2{cur.total[31]}}, cur.total} + {{16{adj[17]}}, adj};

    always_comb
    begin
        upd.prev = angle;
        priority if (sum > SAT_HI)
            upd.total = SAT_HI[31:0];
        else if (sum < SAT_LO)
            upd.total = SAT_LO[31:0];
        else
            upd.total = sum[31:0];
    end

endmodule

### hw/rtl/mfu_state_mem.sv
// Per-motor state memory: registered read, valid bits for reset, write forwarding.
`timescale 1ns / 1ps
module mfu_state_mem #(
    parameter int NUM_MOTORS = 24,
    parameter int IDX_W      = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_idx,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_idx,
    input  mfu_pkg::mfu_entry_t  wr_data,
    output logic                 rd_seeded,
    output mfu_pkg::mfu_entry_t  rd_data
);
    import mfu_pkg::*;

    mfu_entry_t       ram_reg [NUM_MOTORS];
    mfu_entry_t       rdata_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             valid_reg [NUM_MOTORS];
    logic             fwd_valid_reg;
    logic [IDX_W-1:0] fwd_idx_reg;
    mfu_entry_t       fwd_data_reg;
    logic             fwd_hit;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg  <= ram_reg[rd_idx];
            rd_idx_reg <= rd_idx;
        end
    end

    // Most recent write; newer than the array when a read hit the same edge
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_idx_reg  <= wr_idx;
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (wr_en)
        begin
            fwd_valid_reg     <= 1'b1;
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    assign fwd_hit   = fwd_valid_reg && (fwd_idx_reg == rd_idx_reg);
    assign rd_seeded = valid_reg[rd_idx_reg];

    always_comb
    begin
        priority if (!rd_seeded)
            rd_data = '0;
        else if (fwd_hit)
            rd_data = fwd_data_reg;
        else
            rd_data = rdata_reg;
    end

endmodule

### hw/rtl/motor_feedback_unwrap_unit.sv
// Top level of the motor feedback unwrap unit.
// Path: an accepted word is registered in stage 1 (read, update), then in the output register.
// Throughput: one frame word per cycle while the output is not blocked; the update
//   loop is one read-modify-write through the state memory with the last write forwarded to the next read.
// Reset: registered_mask clears to zero, every motor reads as unseeded with zero
//   total through per-entry valid bits; no clearing pass, words accepted at once.
`timescale 1ns / 1ps
module motor_feedback_unwrap_unit #(
    parameter int NUM_BUSES      = mfu_pkg::NUM_BUSES_DEF,
    parameter int MOTORS_PER_BUS = mfu_pkg::MOTORS_PER_BUS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        registered_mask_we,
    input  logic [mfu_pkg::MASK_W-1:0]  registered_mask_data,
    // frame channel
    input  logic                        frame_valid,
    output logic                        frame_stall,
    input  logic [1:0]                  bus_index,
    input  logic [10:0]                 frame_id,
    input  logic [31:0]                 payload_high,
    input  logic [31:0]                 payload_low,
    // result channel
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [1:0]                  motor_bus,
    output logic [3:0]                  motor_slot,
    output logic [15:0]                 encoder_angle,
    output logic signed [15:0]          speed_value,
    output logic signed [15:0]          torque_value,
    output logic [7:0]                  temperature,
    output logic signed [31:0]          multi_turn_angle
);
    import mfu_pkg::*;

    localparam int NUM_MOTORS = NUM_BUSES * MOTORS_PER_BUS;
    localparam int IDX_W      = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

    logic [MASK_W-1:0] registered_mask_reg;

    // Stage 0: decode straight off the ports, launch the memory read
    mfu_frame_t       dec_frame;
    logic [IDX_W-1:0] dec_idx;
    logic             accept;

    // Stage 1: read data back, update, write back and load the output register
    logic             s1_valid_reg;
    mfu_frame_t       s1_frame_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             out_free;
    logic             s1_adv;
    logic             s1_commit;
    logic             seeded;
    mfu_entry_t       cur_entry;
    mfu_entry_t       upd_entry;

    // Output register
    logic               result_valid_reg;
    logic [1:0]         motor_bus_reg;
    logic [3:0]         motor_slot_reg;
    logic [15:0]        encoder_angle_reg;
    logic signed [15:0] speed_value_reg;
    logic signed [15:0] torque_value_reg;
    logic [7:0]         temperature_reg;
    logic signed [31:0] multi_turn_angle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            registered_mask_reg <= '0;
        end
        else if (registered_mask_we)
        begin
            registered_mask_reg <= registered_mask_data;
        end
    end

    mfu_decode #(
        .NUM_BUSES      (NUM_BUSES),
        .MOTORS_PER_BUS (MOTORS_PER_BUS),
        .IDX_W          (IDX_W)
    ) u_decode (
        .bus_index       (bus_index),
        .frame_id        (frame_id),
        .payload_high    (payload_high),
        .payload_low     (payload_low),
        .registered_mask (registered_mask_reg),
        .frame           (dec_frame),
        .idx             (dec_idx)
    );

    // Output slot opens when empty or being drained this cycle.
    // A filtered-out word in stage 1 just drops, it never waits.
    assign out_free    = !result_valid_reg || !result_stall;
    assign s1_adv      = !s1_valid_reg || !s1_frame_reg.hit || out_free;
    assign s1_commit   = s1_valid_reg && s1_frame_reg.hit && out_free;
    assign frame_stall = !s1_adv;
    assign accept      = frame_valid && !frame_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_frame_reg <= dec_frame;
            s1_idx_reg   <= dec_idx;
        end
    end

    // Read on accept; the read-modify-write closes in stage 1, and the
    // memory forwards the previous write when the next word hits the same motor.
    mfu_state_mem #(
        .NUM_MOTORS (NUM_MOTORS),
        .IDX_W      (IDX_W)
    ) u_state_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_idx    (dec_idx),
        .wr_en     (s1_commit),
        .wr_idx    (s1_idx_reg),
        .wr_data   (upd_entry),
        .rd_seeded (seeded),
        .rd_data   (cur_entry)
    );

    mfu_unwrap u_unwrap (
        .angle  (s1_frame_reg.angle),
        .seeded (seeded),
        .cur    (cur_entry),
        .upd    (upd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            result_valid_reg <= s1_commit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_commit)
        begin
            motor_bus_reg        <= s1_frame_reg.bus;
            motor_slot_reg       <= s1_frame_reg.slot;
            encoder_angle_reg    <= s1_frame_reg.angle;
            speed_value_reg      <= s1_frame_reg.speed;
            torque_value_reg     <= s1_frame_reg.torque;
            temperature_reg      <= s1_frame_reg.temp;
            multi_turn_angle_reg <= upd_entry.total;
        end
    end

    assign result_valid     = result_valid_reg;
    assign motor_bus        = motor_bus_reg;
    assign motor_slot       = motor_slot_reg;
    assign encoder_angle    = encoder_angle_reg;
    assign speed_value      = speed_value_reg;
    assign torque_value     = torque_value_reg;
    assign temperature      = temperature_reg;
    assign multi_turn_angle = multi_turn_angle_reg;

endmodule

### hw/rtl/mfu_checker.sv
// Port-level checks of the motor feedback unwrap unit, bound to the top level.
`timescale 1ns / 1ps
`include "motor_feedback_unwrap_unit_macros.svh"
module mfu_checker #(
    parameter int NUM_BUSES      = mfu_pkg::NUM_BUSES_DEF,
    parameter int MOTORS_PER_BUS = mfu_pkg::MOTORS_PER_BUS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               frame_stall,
    input  logic               result_valid,
    input  logic               result_stall,
    input  logic [1:0]         motor_bus,
    input  logic [3:0]         motor_slot,
    input  logic [15:0]        encoder_angle,
    input  logic signed [31:0] multi_turn_angle
);
    import mfu_pkg::*;

    // Only a word that passed the filter can come out
    `MFU_ASSERT_IMP(a_slot_range, clk, rst_n, result_valid, (motor_slot != 4'd0) && (32'(motor_slot) <= MOTORS_PER_BUS), "result slot out of range")
    `MFU_ASSERT_IMP(a_bus_range, clk, rst_n, result_valid, 32'(motor_bus) < NUM_BUSES, "result bus out of range")
    // Input backpressure only comes from a full, blocked output
    `MFU_ASSERT_IMP(a_stall_cause, clk, rst_n, frame_stall, result_valid && result_stall, "frame stall without blocked result")
    `MFU_ASSERT_NXT(a_out_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(multi_turn_angle) && $stable(encoder_angle) && $stable(motor_slot), "stalled result word changed")

endmodule

bind motor_feedback_unwrap_unit mfu_checker #(
    .NUM_BUSES      (NUM_BUSES),
    .MOTORS_PER_BUS (MOTORS_PER_BUS)
) u_mfu_checker (.*);
